@@ hdl/ifl_pkg.sv @@
// ----------------------------------------------------------------------------
// ifl_pkg: shared definitions for the boundary-tag heap allocator
// Heap geometry, tag word layout, operation and status codes, init layout.
// ----------------------------------------------------------------------------
package ifl_pkg;

    localparam int HEAP_WORDS = 16384;
    // tag store word index width
    localparam int AW = $clog2(HEAP_WORDS);
    // tag word: byte size (multiple of 8) with the allocated flag in bit 0
    localparam int SW = AW + 2;
    // width for size arithmetic: holds a rounded 16-bit request
    localparam int XW = (SW > 17) ? SW : 17;
    // width for comparing a payload index with a freed payload index
    localparam int CW = (AW + 1 > 14) ? AW + 1 : 14;

    localparam int N_FREE     = ((HEAP_WORDS - 4) / 2) * 2;
    localparam int FREE_BYTES = N_FREE * 4;
    localparam int MIN_BLOCK  = 16;
    localparam int INIT_WORDS = 5;

    localparam logic [AW-1:0] FIRST_HDR = AW'(3);
    localparam logic [SW-1:0] PRO_TAG   = SW'(9);
    localparam logic [SW-1:0] EPI_TAG   = SW'(1);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [SW-1:0] data;
    } tag_wr_t;

    // Layout of the empty heap: prologue pair, one free block, epilogue.
    function automatic tag_wr_t init_word(input logic [2:0] idx);
        tag_wr_t w;
        w.addr = FIRST_HDR;
        w.data = SW'(FREE_BYTES);
        unique case (idx)
            3'd0:
            begin
                w.addr = AW'(1);
                w.data = PRO_TAG;
            end
            3'd1:
            begin
                w.addr = AW'(2);
                w.data = PRO_TAG;
            end
            3'd2:
            begin
                w.addr = FIRST_HDR;
                w.data = SW'(FREE_BYTES);
            end
            3'd3:
            begin
                w.addr = AW'(2 + N_FREE);
                w.data = SW'(FREE_BYTES);
            end
            3'd4:
            begin
                w.addr = AW'(3 + N_FREE);
                w.data = EPI_TAG;
            end
            default:
            begin
                w.addr = FIRST_HDR;
                w.data = SW'(FREE_BYTES);
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/ifl_if.sv @@
// ----------------------------------------------------------------------------
// ifl_req_if / ifl_rsp_if: request and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface ifl_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] request_size;
    logic [15:0] block_addr;

    modport source (output valid, output opcode, output request_size,
                    output block_addr, input ready);
    modport sink   (input valid, input opcode, input request_size,
                    input block_addr, output ready);
endinterface

interface ifl_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_addr;
    logic [15:0] result_size;
    logic [1:0]  status;

    modport source (output valid, output result_addr, output result_size,
                    output status, input ready);
    modport sink   (input valid, input result_addr, input result_size,
                    input status, output ready);
endinterface

@@ hdl/implicit_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// implicit_free_list_allocator: first-fit boundary-tag heap manager
// Allocates and frees blocks in a tag store held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | transaction payload
//  --------+-----+-----------------------------------------------
//  req     | in  | opcode, request_size, block_addr
//  rsp     | out | result_addr, result_size, status
//
//  An allocate reads headers one per cycle from the tag RAM read port, first
//  fit; a placement writes two tag words, or four when it splits. A merging
//  free walks to the block, then fetches the footer below and the header above.
//  The first transaction after reset first lays out the empty heap.
//  A result waits in the output register while
//  the next transaction is taken; a held result stalls only the finish.
// ----------------------------------------------------------------------------
module implicit_free_list_allocator (
    input  logic      clk,
    input  logic      rst_n,
    ifl_req_if.sink   req,
    ifl_rsp_if.source rsp
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_FPREV = 8'b0001_0000,
        S_FNEXT = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    function automatic logic [15:0] pay_addr(input logic [ifl_pkg::AW-1:0] h);
        logic [31:0] b;
        b = (32'(h) + 32'd1) << 2;
        return b[15:0];
    endfunction

    state_t state_reg, state_next;
    logic   init_done_reg, init_done_next;
    logic [2:0] init_cnt_reg, init_cnt_next;
    logic   out_valid_reg;
    logic   out_load;
    logic   req_fire;

    ifl_pkg::opcode_t       op_reg;
    logic                   ign_reg;
    logic [ifl_pkg::XW-1:0] asize_reg;
    logic [13:0]            target_reg;

    logic [ifl_pkg::AW-1:0] hdr_reg, hdr_next;
    logic [ifl_pkg::SW-1:0] s_reg, s_next;
    logic [ifl_pkg::SW-1:0] prev_reg, prev_next;
    ifl_pkg::tag_wr_t       wq_reg [4];
    ifl_pkg::tag_wr_t       wq_next [4];
    logic [1:0]             wq_idx_reg, wq_idx_next;
    logic [1:0]             wq_last_reg, wq_last_next;
    logic [15:0]            res_addr_reg, res_addr_next;
    logic [15:0]            res_size_reg, res_size_next;
    ifl_pkg::status_t       res_status_reg, res_status_next;
    logic [15:0]            out_addr_reg, out_size_reg;
    ifl_pkg::status_t       out_status_reg;

    logic                   ram_we, ram_re;
    logic [ifl_pkg::AW-1:0] ram_waddr, ram_raddr;
    logic [ifl_pkg::SW-1:0] ram_wdata, ram_rdata;
    ifl_pkg::tag_wr_t       init_w;

    // request decode
    logic [16:0]            req_round;
    logic [ifl_pkg::XW-1:0] req_asize;
    logic                   req_ign;

    // walk datapath
    logic [ifl_pkg::SW-1:0] r_size;
    logic                   r_alloc;
    logic [ifl_pkg::AW-1:0] hdr_adv;
    logic [ifl_pkg::AW:0]   p_cur;
    logic [ifl_pkg::CW-1:0] p_ext, tgt_ext;
    logic [ifl_pkg::XW-1:0] s_ext, rem;
    logic                   fit, split;
    logic [ifl_pkg::AW-1:0] hdr_mid;

    // merge datapath
    logic [ifl_pkg::AW-1:0] nxt_hdr;
    logic                   pa, na;
    logic [ifl_pkg::SW-1:0] ps;
    logic [ifl_pkg::AW-1:0] m_hdr, m_foot;
    logic [ifl_pkg::XW-1:0] m_size;

    ifl_ram #(
        .WIDTH (ifl_pkg::SW),
        .DEPTH (ifl_pkg::HEAP_WORDS)
    ) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // payload rounded up to 8 plus 8 bytes of tags, at least 16
    assign req_round = (17'(req.request_size) + 17'd15) & ~17'd7;
    assign req_asize = (req.request_size <= 16'd8) ? ifl_pkg::XW'(ifl_pkg::MIN_BLOCK)
                                                   : ifl_pkg::XW'(req_round);
    assign req_ign   = (req.opcode == ifl_pkg::OP_ALLOC) ? (req.request_size == 16'd0)
                     : ((req.block_addr == 16'd0) || (req.block_addr[2:0] != 3'd0));

    assign init_w  = ifl_pkg::init_word(init_cnt_reg);
    assign r_size  = {ram_rdata[ifl_pkg::SW-1:3], 3'b000};
    assign r_alloc = ram_rdata[0];
    assign hdr_adv = hdr_reg + r_size[ifl_pkg::SW-1:2];
    assign p_cur   = {1'b0, hdr_reg} + {{ifl_pkg::AW{1'b0}}, 1'b1};
    assign p_ext   = ifl_pkg::CW'(p_cur);
    assign tgt_ext = ifl_pkg::CW'(target_reg);
    assign s_ext   = ifl_pkg::XW'(r_size);
    assign fit     = !r_alloc && (asize_reg <= s_ext);
    assign rem     = s_ext - asize_reg;
    assign split   = rem >= ifl_pkg::XW'(ifl_pkg::MIN_BLOCK);
    assign hdr_mid = hdr_reg + asize_reg[ifl_pkg::AW+1:2];

    assign nxt_hdr = hdr_reg + s_reg[ifl_pkg::SW-1:2];
    assign pa      = prev_reg[0];
    assign ps      = {prev_reg[ifl_pkg::SW-1:3], 3'b000};
    assign na      = r_alloc;
    assign m_hdr   = pa ? hdr_reg : (hdr_reg - ps[ifl_pkg::SW-1:2]);
    assign m_size  = ifl_pkg::XW'(s_reg)
                   + (pa ? '0 : ifl_pkg::XW'(ps))
                   + (na ? '0 : s_ext);
    assign m_foot  = na ? (nxt_hdr - ifl_pkg::AW'(1))
                        : (nxt_hdr + r_size[ifl_pkg::SW-1:2] - ifl_pkg::AW'(1));

    always_comb
    begin
        state_next      = state_reg;
        init_done_next  = init_done_reg;
        init_cnt_next   = init_cnt_reg;
        hdr_next        = hdr_reg;
        s_next          = s_reg;
        prev_next       = prev_reg;
        wq_next         = wq_reg;
        wq_idx_next     = wq_idx_reg;
        wq_last_next    = wq_last_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = wq_reg[wq_idx_reg].addr;
        ram_wdata       = wq_reg[wq_idx_reg].data;
        ram_re          = 1'b0;
        ram_raddr       = hdr_adv;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    init_cnt_next = 3'd0;
                    state_next    = init_done_reg ? S_START : S_INIT;
                end
            end
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_w.addr;
                ram_wdata = init_w.data;
                if (init_cnt_reg == 3'(ifl_pkg::INIT_WORDS - 1))
                begin
                    init_done_next = 1'b1;
                    state_next     = S_START;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + 3'd1;
                end
            end
            S_START:
            begin
                if (ign_reg)
                begin
                    res_addr_next   = 16'd0;
                    res_size_next   = 16'd0;
                    res_status_next = ifl_pkg::ST_IGNORED;
                    state_next      = S_OUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ifl_pkg::FIRST_HDR;
                    hdr_next   = ifl_pkg::FIRST_HDR;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                res_addr_next = 16'd0;
                res_size_next = 16'd0;
                if (op_reg == ifl_pkg::OP_ALLOC)
                begin
                    if (r_size == '0)
                    begin
                        res_status_next = ifl_pkg::ST_NOFIT;
                        state_next      = S_OUT;
                    end
                    else if (fit)
                    begin
                        wq_idx_next     = 2'd0;
                        res_addr_next   = pay_addr(hdr_reg);
                        res_status_next = ifl_pkg::ST_DONE;
                        state_next      = S_WR;
                        if (split)
                        begin
                            wq_next[0].addr = hdr_reg;
                            wq_next[0].data = ifl_pkg::SW'(asize_reg) | ifl_pkg::SW'(1);
                            wq_next[1].addr = hdr_mid - ifl_pkg::AW'(1);
                            wq_next[1].data = ifl_pkg::SW'(asize_reg) | ifl_pkg::SW'(1);
                            wq_next[2].addr = hdr_mid;
                            wq_next[2].data = ifl_pkg::SW'(rem);
                            wq_next[3].addr = hdr_adv - ifl_pkg::AW'(1);
                            wq_next[3].data = ifl_pkg::SW'(rem);
                            wq_last_next    = 2'd3;
                            res_size_next   = 16'(asize_reg);
                        end
                        else
                        begin
                            wq_next[0].addr = hdr_reg;
                            wq_next[0].data = r_size | ifl_pkg::SW'(1);
                            wq_next[1].addr = hdr_adv - ifl_pkg::AW'(1);
                            wq_next[1].data = r_size | ifl_pkg::SW'(1);
                            wq_last_next    = 2'd1;
                            res_size_next   = 16'(r_size);
                        end
                    end
                    else
                    begin
                        // advance to the next header
                        ram_re   = 1'b1;
                        hdr_next = hdr_adv;
                    end
                end
                else
                begin
                    if ((r_size == '0) || (p_ext > tgt_ext))
                    begin
                        res_status_next = ifl_pkg::ST_IGNORED;
                        state_next      = S_OUT;
                    end
                    else if (p_ext == tgt_ext)
                    begin
                        if (!r_alloc)
                        begin
                            res_status_next = ifl_pkg::ST_IGNORED;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            // fetch the footer of the block below
                            s_next     = r_size;
                            ram_re     = 1'b1;
                            ram_raddr  = hdr_reg - ifl_pkg::AW'(1);
                            state_next = S_FPREV;
                        end
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        hdr_next = hdr_adv;
                    end
                end
            end
            S_FPREV:
            begin
                // fetch the header of the block above
                prev_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = nxt_hdr;
                state_next = S_FNEXT;
            end
            S_FNEXT:
            begin
                wq_next[0].addr = m_hdr;
                wq_next[0].data = ifl_pkg::SW'(m_size);
                wq_next[1].addr = m_foot;
                wq_next[1].data = ifl_pkg::SW'(m_size);
                wq_idx_next     = 2'd0;
                wq_last_next    = 2'd1;
                res_addr_next   = pay_addr(m_hdr);
                res_size_next   = 16'(m_size);
                res_status_next = ifl_pkg::ST_DONE;
                state_next      = S_WR;
            end
            S_WR:
            begin
                // drain the tag updates before any further read
                ram_we = 1'b1;
                if (wq_idx_reg == wq_last_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    wq_idx_next = wq_idx_reg + 2'd1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_done_reg <= 1'b0;
            init_cnt_reg  <= 3'd0;
            wq_idx_reg    <= 2'd0;
            wq_last_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_done_reg <= init_done_next;
            init_cnt_reg  <= init_cnt_next;
            wq_idx_reg    <= wq_idx_next;
            wq_last_reg   <= wq_last_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= ifl_pkg::opcode_t'(req.opcode);
            ign_reg    <= req_ign;
            asize_reg  <= req_asize;
            target_reg <= req.block_addr[15:2];
        end
        hdr_reg        <= hdr_next;
        s_reg          <= s_next;
        prev_reg       <= prev_next;
        wq_reg         <= wq_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_size_reg   <= res_size_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_addr = out_addr_reg;
    assign rsp.result_size = out_size_reg;
    assign rsp.status      = out_status_reg;

    // the tag RAM is written only while laying out or committing updates
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_INIT) || (state_reg == S_WR)))
        else $error("tag write outside init or commit");

    // no read and write in the same cycle, so no same-entry overlap
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("tag read issued while writing");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> ((state_reg == S_INIT) || (state_reg == S_START)))
        else $error("accepted transaction not started");

    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        init_done_reg |=> init_done_reg)
        else $error("heap layout flag dropped");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("pending result overwritten");

    a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ifl_pkg::ST_DONE)) |-> (rsp.result_size != 16'd0))
        else $error("completed result with zero size");

endmodule

@@ hdl/ifl_ram.sv @@
// ----------------------------------------------------------------------------
// ifl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
module ifl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
